/* rtl/c16df_pkg.sv */
// ----------------------------------------------------------------------------
// c16df_pkg
// Types, constants and the byte-wide CRC-16 update shared by the deframer.
// ----------------------------------------------------------------------------
package c16df_pkg;

  localparam logic [7:0]  START_BYTE = 8'h02;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h1021;

  localparam logic [15:0] MAX_SIZE_RST = 16'd512;
  localparam logic [15:0] TIMEOUT_RST  = 16'd1000;

  // configuration register indexes
  localparam logic CFG_MAX_SIZE = 1'b0;
  localparam logic CFG_TIMEOUT  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_HDR_CRC   = 3'd1,
    ST_DATA_CRC  = 3'd2,
    ST_SHORT     = 3'd3,
    ST_OVERSIZE  = 3'd4,
    ST_TIMEOUT   = 3'd5
  } status_e;

  typedef enum logic {
    MODE_BYTE = 1'b0,
    MODE_TICK = 1'b1
  } mode_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    status_e     status;
    logic [15:0] payload_length;
  } out_item_t;

  typedef struct packed {
    logic [15:0] max_size;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // crc-16/ccitt-false, one byte, msb first
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/c16df_core.sv */
// ----------------------------------------------------------------------------
// c16df_core
// Frame state and per-item next-state logic; yields at most one result.
// ----------------------------------------------------------------------------
module c16df_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_fire_i,
  input  c16df_pkg::in_item_t  item_i,
  input  c16df_pkg::cfg_t      cfg_i,
  output logic                 res_valid_o,
  output c16df_pkg::out_item_t res_o
);

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_HEAD = 3'b010,
    PH_DATA = 3'b100
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic [15:0] size_q, size_d;
  logic [15:0] hdr_crc_q, hdr_crc_d;
  logic [15:0] data_cnt_q, data_cnt_d;
  logic [15:0] data_crc_q, data_crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [15:0] idle_q, idle_d;

  logic [15:0] idle_inc;
  logic [15:0] rx_crc;
  logic [15:0] size_m2;
  logic [15:0] data_cnt_inc;
  logic [7:0]  b;

  assign b            = item_i.rx_byte;
  assign idle_inc     = (&idle_q) ? idle_q : idle_q + 16'd1;
  assign rx_crc       = {b, crc_lo_q};
  assign size_m2      = size_q - 16'd2;
  assign data_cnt_inc = data_cnt_q + 16'd1;

  always_comb begin
    logic to_hunt;
    to_hunt     = 1'b0;
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    size_d      = size_q;
    hdr_crc_d   = hdr_crc_q;
    data_cnt_d  = data_cnt_q;
    data_crc_d  = data_crc_q;
    crc_lo_d    = crc_lo_q;
    idle_d      = idle_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: c16df_pkg::KIND_STATUS, payload_byte: 8'h00,
                    status: c16df_pkg::ST_OK, payload_length: 16'h0000};

    if (item_i.mode == c16df_pkg::MODE_TICK) begin
      if (phase_q == PH_HEAD || phase_q == PH_DATA) begin
        idle_d = idle_inc;
        if (idle_inc >= cfg_i.timeout_ticks) begin
          res_valid_o  = 1'b1;
          res_o.status = c16df_pkg::ST_TIMEOUT;
          to_hunt      = 1'b1;
        end
      end
    end else begin
      case (phase_q)
        PH_HEAD: begin
          idle_d    = '0;
          hdr_cnt_d = hdr_cnt_q + 3'd1;
          case (hdr_cnt_q)
            3'd0: begin
              size_d    = {8'h00, b};
              hdr_crc_d = c16df_pkg::crc_add(hdr_crc_q, b);
            end
            3'd1: begin
              size_d    = {b, size_q[7:0]};
              hdr_crc_d = c16df_pkg::crc_add(hdr_crc_q, b);
            end
            3'd2: begin
              crc_lo_d = b;
            end
            default: begin
              if (rx_crc != hdr_crc_q) begin
                res_valid_o  = 1'b1;
                res_o.status = c16df_pkg::ST_HDR_CRC;
                to_hunt      = 1'b1;
              end else if (size_q < 16'd2) begin
                res_valid_o  = 1'b1;
                res_o.status = c16df_pkg::ST_SHORT;
                to_hunt      = 1'b1;
              end else if (size_q > cfg_i.max_size) begin
                res_valid_o  = 1'b1;
                res_o.status = c16df_pkg::ST_OVERSIZE;
                to_hunt      = 1'b1;
              end else begin
                phase_d    = PH_DATA;
                hdr_cnt_d  = '0;
                data_cnt_d = '0;
                data_crc_d = c16df_pkg::CRC_INIT;
                crc_lo_d   = '0;
              end
            end
          endcase
        end
        PH_DATA: begin
          idle_d     = '0;
          data_cnt_d = data_cnt_inc;
          if (data_cnt_inc <= size_m2) begin
            data_crc_d         = c16df_pkg::crc_add(data_crc_q, b);
            res_valid_o        = 1'b1;
            res_o.kind         = c16df_pkg::KIND_PAYLOAD;
            res_o.payload_byte = b;
          end else if (data_cnt_inc < size_q) begin
            crc_lo_d = b;
          end else begin
            res_valid_o = 1'b1;
            to_hunt     = 1'b1;
            if (rx_crc != data_crc_q) begin
              res_o.status = c16df_pkg::ST_DATA_CRC;
            end else begin
              res_o.payload_length = size_m2;
            end
          end
        end
        default: begin
          // hunting, also covers any stray phase code
          phase_d = PH_HUNT;
          if (b == c16df_pkg::START_BYTE) begin
            phase_d    = PH_HEAD;
            hdr_cnt_d  = '0;
            size_d     = '0;
            hdr_crc_d  = c16df_pkg::crc_add(c16df_pkg::CRC_INIT, b);
            data_cnt_d = '0;
            data_crc_d = c16df_pkg::CRC_INIT;
            crc_lo_d   = '0;
            idle_d     = '0;
          end
        end
      endcase
    end

    if (to_hunt) begin
      phase_d    = PH_HUNT;
      hdr_cnt_d  = '0;
      size_d     = '0;
      hdr_crc_d  = c16df_pkg::CRC_INIT;
      data_cnt_d = '0;
      data_crc_d = c16df_pkg::CRC_INIT;
      crc_lo_d   = '0;
      idle_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      hdr_cnt_q  <= '0;
      size_q     <= '0;
      hdr_crc_q  <= c16df_pkg::CRC_INIT;
      data_cnt_q <= '0;
      data_crc_q <= c16df_pkg::CRC_INIT;
      crc_lo_q   <= '0;
      idle_q     <= '0;
    end else if (item_fire_i) begin
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      size_q     <= size_d;
      hdr_crc_q  <= hdr_crc_d;
      data_cnt_q <= data_cnt_d;
      data_crc_q <= data_crc_d;
      crc_lo_q   <= crc_lo_d;
      idle_q     <= idle_d;
    end
  end

endmodule

/* rtl/crc16_packet_deframer_top.sv */
// output: a result is registered and appears in the cycle after its input transfer
// throughput: one item per cycle unless the output stalls; the crc byte update
//   and frame checks sit in one stage between frame state and output register
// reset: rst_ni is asynchronous, active low; the deframer hunts for a start
//   byte, the output register is empty and the registers take their defaults
// ----------------------------------------------------------------------------
// crc16_packet_deframer_top
// Start-byte / length / crc-16 framed byte stream deframer.
// ----------------------------------------------------------------------------
module crc16_packet_deframer_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  c16df_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output c16df_pkg::out_item_t out_data_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i
);

  c16df_pkg::cfg_t      cfg_q;
  logic                 out_valid_q, out_valid_d;
  c16df_pkg::out_item_t out_q;
  logic                 in_fire;
  logic                 res_valid;
  c16df_pkg::out_item_t res;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  c16df_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_fire_i (in_fire),
    .item_i      (in_data_i),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_size      <= c16df_pkg::MAX_SIZE_RST;
      cfg_q.timeout_ticks <= c16df_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        c16df_pkg::CFG_MAX_SIZE: cfg_q.max_size      <= cfg_wdata_i;
        c16df_pkg::CFG_TIMEOUT:  cfg_q.timeout_ticks <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // output register refills on the same edge it is drained
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/c16df_checker.sv */
// ----------------------------------------------------------------------------
// c16df_checker
// Port-level checks on the deframer's result stream.
// ----------------------------------------------------------------------------
module c16df_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input c16df_pkg::out_item_t out_data_o
);

  // a held result keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == c16df_pkg::KIND_PAYLOAD |->
      out_data_o.status == c16df_pkg::ST_OK && out_data_o.payload_length == 16'h0000)
    else $error("payload transfer carries status fields");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == c16df_pkg::KIND_STATUS |->
      out_data_o.status == c16df_pkg::ST_OK || out_data_o.status == c16df_pkg::ST_HDR_CRC ||
      out_data_o.status == c16df_pkg::ST_DATA_CRC || out_data_o.status == c16df_pkg::ST_SHORT ||
      out_data_o.status == c16df_pkg::ST_OVERSIZE || out_data_o.status == c16df_pkg::ST_TIMEOUT)
    else $error("undefined status code");

  a_error_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == c16df_pkg::KIND_STATUS &&
      out_data_o.status != c16df_pkg::ST_OK |-> out_data_o.payload_length == 16'h0000
      && out_data_o.payload_byte == 8'h00)
    else $error("failed frame reports a length");

endmodule

bind crc16_packet_deframer_top c16df_checker u_c16df_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
